>>> rtl/eavc_pkg.sv
// Shared types, constants and the control program of the encoder angle variance check.
package eavc_pkg;

    localparam int NUM_SAMPLES_DEF = 8;

    localparam int RAW_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int FAIL_W  = 8;
    localparam int VAR_W   = 29;

    localparam int FULL_TURN = 46080;
    localparam int HALF_TURN = 23040;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NULL_ANGLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VARIANCE = 1'd1;
    localparam logic [VAR_W-1:0]     MAX_VAR_RESET    = 29'd16384;

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_UPDATE,
        OP_SQUARE,
        OP_ACC,
        OP_SUM_SQ,
        OP_VAR_LOAD,
        OP_DIV,
        OP_VAR,
        OP_MEAN_LOAD,
        OP_MEAN,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_DIV,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_NOT_LAST
    } jmp_t;

    typedef struct packed {
        op_t              op;
        hold_t            hold;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic last;
        logic div_more;
    } stat_t;

    localparam logic [PC_W-1:0] STEP_TAKE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_UPDATE    = 4'd1;
    localparam logic [PC_W-1:0] STEP_SQUARE    = 4'd2;
    localparam logic [PC_W-1:0] STEP_ACC       = 4'd3;
    localparam logic [PC_W-1:0] STEP_SUM_SQ    = 4'd4;
    localparam logic [PC_W-1:0] STEP_VAR_LOAD  = 4'd5;
    localparam logic [PC_W-1:0] STEP_VAR_DIV   = 4'd6;
    localparam logic [PC_W-1:0] STEP_VAR       = 4'd7;
    localparam logic [PC_W-1:0] STEP_MEAN_LOAD = 4'd8;
    localparam logic [PC_W-1:0] STEP_MEAN_DIV  = 4'd9;
    localparam logic [PC_W-1:0] STEP_MEAN      = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT      = 4'd11;

    // Control store: one word per step.
    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t w;
        unique case (pc)
            STEP_TAKE:      w = '{OP_TAKE,      HOLD_IN,   JMP_NEXT,     STEP_TAKE};
            STEP_UPDATE:    w = '{OP_UPDATE,    HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_SQUARE:    w = '{OP_SQUARE,    HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_ACC:       w = '{OP_ACC,       HOLD_NONE, JMP_NOT_LAST, STEP_EMIT};
            STEP_SUM_SQ:    w = '{OP_SUM_SQ,    HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_VAR_LOAD:  w = '{OP_VAR_LOAD,  HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_VAR_DIV:   w = '{OP_DIV,       HOLD_DIV,  JMP_NEXT,     STEP_TAKE};
            STEP_VAR:       w = '{OP_VAR,       HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_MEAN_LOAD: w = '{OP_MEAN_LOAD, HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_MEAN_DIV:  w = '{OP_DIV,       HOLD_DIV,  JMP_NEXT,     STEP_TAKE};
            STEP_MEAN:      w = '{OP_MEAN,      HOLD_NONE, JMP_NEXT,     STEP_TAKE};
            STEP_EMIT:      w = '{OP_EMIT,      HOLD_OUT,  JMP_ALWAYS,   STEP_TAKE};
            default:        w = '{OP_NOP,       HOLD_NONE, JMP_ALWAYS,   STEP_TAKE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/encoder_angle_variance_check.sv
// Top level of the encoder angle variance check: ports, configuration registers, wiring.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  s_axis   | s_axis_tvalid/tready   | tdata: raw_angle; tuser: read_failed
//  m_axis   | m_axis_tvalid/tready   | tdata: angle, fail_count, average, variance;
//           |                        | tlast: batch_done; tuser: stable
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// An item that ends no batch runs the steps take, update, square, accumulate and emit.
// The last item of a batch also runs sum of squares, variance and mean before emit:
// variance and mean are each divided by a constant, working through the dividend one
// 16-bit digit at a time.
// Reset clears the control and batch registers at once; there is no clearing pass.
// The sequencer waits at its take step for an input item, and at its emit step only
// while an earlier result still sits untaken in the output register.
module encoder_angle_variance_check
    import eavc_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] raw_angle
    input  logic                 s_axis_tuser,   // [0] read_failed
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,   // [15:0] angle, [23:16] fail_count,
                                                 // [39:24] average, [68:40] variance
    output logic                 m_axis_tlast,   // batch_done
    output logic                 m_axis_tuser,   // [0] stable
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_W-1:0]     cfg_data
);

    logic [RAW_W-1:0]          null_angle_reg;
    logic [VAR_W-1:0]          max_variance_reg;
    ctl_t                      ctl;
    stat_t                     stat;
    logic signed [ANGLE_W-1:0] angle;
    logic [FAIL_W-1:0]         fail_count;
    logic signed [ANGLE_W-1:0] average;
    logic [VAR_W-1:0]          variance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_angle_reg   <= '0;
            max_variance_reg <= MAX_VAR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NULL_ANGLE:   null_angle_reg   <= cfg_data[RAW_W-1:0];
                REG_MAX_VARIANCE: max_variance_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    eavc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    eavc_dpath #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .null_angle   (null_angle_reg),
        .max_variance (max_variance_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .raw_angle    (s_axis_tdata),
        .read_failed  (s_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .angle        (angle),
        .fail_count   (fail_count),
        .batch_done   (m_axis_tlast),
        .average      (average),
        .variance     (variance),
        .stable       (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, variance, average, fail_count, angle};

endmodule

>>> rtl/eavc_seq.sv
// Microprogram sequencer: step counter, control store lookup and jumps.
module eavc_seq
    import eavc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            held;

    assign ctl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.hold)
            HOLD_NONE: held = 1'b0;
            HOLD_IN:   held = !stat.in_valid;
            HOLD_DIV:  held = stat.div_more;
            HOLD_OUT:  held = stat.out_busy;
            default:   held = 1'b0;
        endcase
    end

    always_comb
    begin
        if (held)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            unique case (ctl.jmp)
                JMP_NEXT:     pc_next = pc_reg + 1'b1;
                JMP_ALWAYS:   pc_next = ctl.target;
                JMP_NOT_LAST: pc_next = stat.last ? pc_reg + 1'b1 : ctl.target;
                default:      pc_next = STEP_TAKE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_TAKE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_EMIT)
        else $error("step counter left the program");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.hold == HOLD_DIV && !stat.div_more) |=> pc_reg == $past(pc_reg) + 1'b1)
        else $error("divide step did not advance when finished");

endmodule

>>> rtl/eavc_div.sv
// Division by the constant NUM_SAMPLES or its square, one 16-bit quotient digit at a time.
module eavc_div
    import eavc_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int DVD_W       = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             step,
    input  logic             by_square,
    input  logic [DVD_W-1:0] dividend,
    output logic [DVD_W-1:0] quotient,
    output logic             more
);

    localparam int DIG_W  = 16;
    localparam int NDIG   = (DVD_W + DIG_W - 1) / DIG_W;
    localparam int PAD_W  = NDIG * DIG_W;
    localparam int NN     = NUM_SAMPLES * NUM_SAMPLES;
    localparam int L_N    = $clog2(NUM_SAMPLES);
    localparam int L_NN   = $clog2(NN);
    localparam int REM_W  = L_NN;
    localparam int X_W    = REM_W + DIG_W;
    localparam int RCP_W  = L_NN + DIG_W + 2;
    localparam int PROD_W = X_W + RCP_W;
    localparam int SH_N   = DIG_W + 2 * L_N;
    localparam int SH_NN  = DIG_W + 2 * L_NN;
    localparam longint RCP_N  = ((longint'(1) << SH_N) + NUM_SAMPLES - 1) / NUM_SAMPLES;
    localparam longint RCP_NN = ((longint'(1) << SH_NN) + NN - 1) / NN;
    localparam int CNT_W  = $clog2(2 * NDIG + 1);

    logic [PAD_W-1:0]  q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIG_W-1:0]  qd_reg;
    logic              by_sq_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [X_W-1:0]    x;
    logic [RCP_W-1:0]  rcp;
    logic [PROD_W-1:0] prod;
    logic [DIG_W-1:0]  qd;
    logic [X_W-1:0]    dvs;
    logic [X_W-1:0]    rem_full;

    // Each partial dividend is the running remainder, which stays below the divisor, with
    // the next 16 dividend bits; the rounded-up reciprocal is exact over that whole range.
    assign x        = {rem_reg, q_reg[PAD_W-1 -: DIG_W]};
    assign rcp      = by_sq_reg ? RCP_W'(RCP_NN) : RCP_W'(RCP_N);
    assign prod     = PROD_W'(x) * PROD_W'(rcp);
    assign qd       = by_sq_reg ? prod[SH_NN +: DIG_W] : prod[SH_N +: DIG_W];
    assign dvs      = by_sq_reg ? X_W'(NN) : X_W'(NUM_SAMPLES);
    assign rem_full = x - X_W'(qd_reg) * dvs;
    assign quotient = q_reg[DVD_W-1:0];
    assign more     = cnt_reg > CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= CNT_W'(2 * NDIG);
        end
        else if (step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Even counts form the quotient digit, odd counts update the remainder and shift it in.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg     <= PAD_W'(dividend);
            rem_reg   <= '0;
            by_sq_reg <= by_square;
        end
        else if (step && !cnt_reg[0])
        begin
            qd_reg <= qd;
        end
        else if (step)
        begin
            q_reg   <= {q_reg[PAD_W-DIG_W-1:0], qd_reg};
            rem_reg <= rem_full[REM_W-1:0];
        end
    end

    a_step_counted: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> cnt_reg != '0)
        else $error("divide step issued with no digits left");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (X_W'(rem_reg) < dvs))
        else $error("running remainder reached the divisor");

endmodule

>>> rtl/eavc_dpath.sv
// Datapath: angle nulling and wrap, failure count, batch sums, shared multiplier, results.
module eavc_dpath
    import eavc_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_t                      ctl,
    output stat_t                     stat,
    input  logic [RAW_W-1:0]          null_angle,
    input  logic [VAR_W-1:0]          max_variance,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [RAW_W-1:0]          raw_angle,
    input  logic                      read_failed,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ANGLE_W-1:0] angle,
    output logic [FAIL_W-1:0]         fail_count,
    output logic                      batch_done,
    output logic signed [ANGLE_W-1:0] average,
    output logic [VAR_W-1:0]          variance,
    output logic                      stable
);

    localparam int L      = $clog2(NUM_SAMPLES);
    localparam int IDX_W  = L;
    localparam int SUM_W  = ANGLE_W + L;
    localparam int SQ_W   = VAR_W + L;
    localparam int PROD_W = 2 * SUM_W;
    localparam int DVD_W  = VAR_W + 1 + 2 * L;
    localparam int DIFF_W = DVD_W + 1;
    localparam int WRAP_W = RAW_W + 2;

    localparam logic [IDX_W-1:0]        IDX_LAST  = IDX_W'(NUM_SAMPLES - 1);
    localparam logic [DVD_W-1:0]        MEAN_BIAS = DVD_W'(NUM_SAMPLES) << (ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0]      AVG_BIAS  = ANGLE_W'(1) << (ANGLE_W - 1);
    localparam logic signed [WRAP_W-1:0] HALF_W   = WRAP_W'(HALF_TURN);
    localparam logic signed [WRAP_W-1:0] FULL_W   = WRAP_W'(FULL_TURN);
    localparam logic [FAIL_W-1:0]       FAIL_MAX  = '1;

    logic [RAW_W-1:0]          raw_reg;
    logic                      failed_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [FAIL_W-1:0]         fail_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      done_reg;
    logic signed [ANGLE_W-1:0] avg_reg;
    logic [VAR_W-1:0]          var_reg;
    logic                      stable_reg;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic [FAIL_W-1:0]         out_fail_reg;
    logic                      out_done_reg;
    logic signed [ANGLE_W-1:0] out_avg_reg;
    logic [VAR_W-1:0]          out_var_reg;
    logic                      out_stable_reg;

    logic signed [WRAP_W-1:0]  diff;
    logic signed [WRAP_W-1:0]  wrapped;
    logic signed [SUM_W-1:0]   angle_ext;
    logic signed [SUM_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]  mul_p;
    logic [DIFF_W-1:0]         nsq;
    logic signed [DIFF_W-1:0]  num;
    logic [DVD_W-1:0]          var_dvd;
    logic [DVD_W-1:0]          mean_dvd;
    logic [DVD_W-1:0]          dvd_sel;
    logic [DVD_W-1:0]          quot;
    logic                      div_load;
    logic                      div_more;
    logic [VAR_W-1:0]          var_sat;
    logic                      last;
    logic                      out_busy;

    assign diff = $signed({2'b00, raw_reg}) - $signed({2'b00, null_angle});

    // One wrap by a full turn lands every 16-bit difference inside half a turn.
    always_comb
    begin
        priority if (diff > HALF_W)
        begin
            wrapped = diff - FULL_W;
        end
        else if (diff < -HALF_W)
        begin
            wrapped = diff + FULL_W;
        end
        else
        begin
            wrapped = diff;
        end
    end

    assign angle_ext = {{(SUM_W - ANGLE_W){angle_reg[ANGLE_W-1]}}, angle_reg};
    assign mul_a     = (ctl.op == OP_SUM_SQ) ? sum_reg : angle_ext;
    assign mul_p     = mul_a * mul_a;

    assign nsq      = DIFF_W'(sq_reg) * DIFF_W'(NUM_SAMPLES);
    assign num      = $signed(nsq) - $signed(prod_reg[DIFF_W-1:0]);
    assign var_dvd  = num[DIFF_W-1] ? '0 : num[DVD_W-1:0];
    assign mean_dvd = {{(DVD_W - SUM_W){sum_reg[SUM_W-1]}}, sum_reg} + MEAN_BIAS;

    assign div_load = (ctl.op == OP_VAR_LOAD) || (ctl.op == OP_MEAN_LOAD);
    assign dvd_sel  = (ctl.op == OP_MEAN_LOAD) ? mean_dvd : var_dvd;

    eavc_div #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .DVD_W       (DVD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .step      (ctl.op == OP_DIV),
        .by_square (ctl.op == OP_VAR_LOAD),
        .dividend  (dvd_sel),
        .quotient  (quot),
        .more      (div_more)
    );

    assign var_sat  = (|quot[DVD_W-1:VAR_W]) ? '1 : quot[VAR_W-1:0];
    assign last     = idx_reg == IDX_LAST;
    assign out_busy = out_valid_reg && !out_ready;

    assign stat     = '{in_valid: in_valid, out_busy: out_busy, last: last, div_more: div_more};
    assign in_ready = ctl.op == OP_TAKE;

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_TAKE && in_valid)
        begin
            raw_reg    <= raw_angle;
            failed_reg <= read_failed;
        end
        if (ctl.op == OP_SQUARE || ctl.op == OP_SUM_SQ)
        begin
            prod_reg <= mul_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= '0;
            fail_reg   <= '0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            done_reg   <= 1'b0;
            avg_reg    <= '0;
            var_reg    <= '0;
            stable_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                OP_UPDATE:
                begin
                    if (failed_reg)
                    begin
                        fail_reg <= (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + 1'b1;
                    end
                    else
                    begin
                        angle_reg <= wrapped[ANGLE_W-1:0];
                        fail_reg  <= '0;
                    end
                    done_reg   <= 1'b0;
                    avg_reg    <= '0;
                    var_reg    <= '0;
                    stable_reg <= 1'b0;
                end
                OP_ACC:
                begin
                    sum_reg  <= sum_reg + angle_ext;
                    sq_reg   <= sq_reg + prod_reg[SQ_W-1:0];
                    idx_reg  <= last ? '0 : idx_reg + 1'b1;
                    done_reg <= last;
                end
                OP_VAR:
                begin
                    var_reg    <= var_sat;
                    stable_reg <= var_sat <= max_variance;
                end
                OP_MEAN:
                begin
                    avg_reg <= quot[ANGLE_W-1:0] - AVG_BIAS;
                    sum_reg <= '0;
                    sq_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.op == OP_EMIT && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_EMIT && !out_busy)
        begin
            out_angle_reg  <= angle_reg;
            out_fail_reg   <= fail_reg;
            out_done_reg   <= done_reg;
            out_avg_reg    <= avg_reg;
            out_var_reg    <= var_reg;
            out_stable_reg <= stable_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign angle      = out_angle_reg;
    assign fail_count = out_fail_reg;
    assign batch_done = out_done_reg;
    assign average    = out_avg_reg;
    assign variance   = out_var_reg;
    assign stable     = out_stable_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_reg <= ANGLE_W'(HALF_TURN)) && (angle_reg >= -ANGLE_W'(HALF_TURN)))
        else $error("current angle outside half a turn");

    a_batch_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |->
            (out_avg_reg == '0 && out_var_reg == '0 && !out_stable_reg))
        else $error("batch fields set on an item that ends no batch");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_ACC && last) |=> (done_reg && idx_reg == '0))
        else $error("last sample did not close the batch");

endmodule
